// File: rtl/cqs_pkg.sv
`timescale 1ns / 1ps
package cqs_pkg;

	// operation codes
	localparam logic [1:0] MODE_ENQ  = 2'd0;
	localparam logic [1:0] MODE_DEQ  = 2'd1;
	localparam logic [1:0] MODE_SRCH = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_EMPTY    = 2'd2;
	localparam logic [1:0] STAT_NOTFOUND = 2'd3;

	localparam int WORD_W = 32;
	localparam int POS_W  = 5;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] data;
		logic [POS_W-1:0]         position;
	} rsp_t;

endpackage

// File: rtl/cqs_store.sv
`timescale 1ns / 1ps
module cqs_store #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [$clog2(DEPTH)-1:0]    wr_addr,
	input  logic [cqs_pkg::WORD_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [$clog2(DEPTH)-1:0]    rd_addr,
	output logic [cqs_pkg::WORD_W-1:0]  rd_data
);
	import cqs_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/cqs_ctrl.sv
`timescale 1ns / 1ps
module cqs_ctrl #(
	parameter int DEPTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  cqs_pkg::req_t               req_data,
	output logic                        res_valid,
	input  logic                        res_take,
	output cqs_pkg::rsp_t               res,
	output logic                        wr_en,
	output logic [$clog2(DEPTH)-1:0]    wr_addr,
	output logic [cqs_pkg::WORD_W-1:0]  wr_data,
	output logic                        rd_en,
	output logic [$clog2(DEPTH)-1:0]    rd_addr,
	input  logic [cqs_pkg::WORD_W-1:0]  rd_data
);
	import cqs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DEQ  = 4'b0010,
		ST_SRCH = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic              empty_q;
	logic [AW-1:0]     slot_q;
	logic [CW-1:0]     count_q;
	logic [WORD_W-1:0] word_q;
	rsp_t              res_q;

	logic              accept;
	logic              full;
	logic              hit;
	logic [AW-1:0]     tail_nxt;
	logic [AW-1:0]     head_nxt;
	logic [AW-1:0]     slot_nxt;
	logic [PW-1:0]     pos_ext;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
		next_slot = (i == LAST) ? '0 : i + 1'b1;
	endfunction

	assign accept    = req_valid && (state_q == ST_IDLE);
	assign req_stall = (state_q != ST_IDLE);
	assign tail_nxt  = next_slot(tail_q);
	assign head_nxt  = next_slot(head_q);
	assign slot_nxt  = next_slot(slot_q);
	assign full      = !empty_q && (tail_nxt == head_q);
	assign hit       = (rd_data == word_q);
	assign pos_ext   = PW'(count_q);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// memory port drive
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = empty_q ? '0 : tail_nxt;
		wr_data = req_data.value;
		rd_en   = 1'b0;
		rd_addr = head_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_data.mode == MODE_ENQ) begin
						wr_en = !full;
					end else if (req_data.mode == MODE_DEQ || req_data.mode == MODE_SRCH) begin
						rd_en = !empty_q;
					end
				end
			end
			ST_SRCH: begin
				rd_addr = slot_nxt;
				rd_en   = !hit && (slot_q != tail_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DONE;
						case (req_data.mode)
							MODE_ENQ: begin
								if (empty_q) begin
									head_q  <= '0;
									tail_q  <= '0;
									empty_q <= 1'b0;
								end else if (!full) begin
									tail_q <= tail_nxt;
								end
							end
							MODE_DEQ: begin
								if (!empty_q) begin
									state_q <= ST_DEQ;
									if (head_q == tail_q) begin
										empty_q <= 1'b1;
										head_q  <= '0;
										tail_q  <= '0;
									end else begin
										head_q <= head_nxt;
									end
								end
							end
							MODE_SRCH: begin
								if (!empty_q) begin
									state_q <= ST_SRCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DEQ: begin
					state_q <= ST_DONE;
				end
				ST_SRCH: begin
					if (hit || slot_q == tail_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search walk and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				slot_q  <= head_q;
				count_q <= CW'(1);
				word_q  <= req_data.value;
				res_q.status   <= STAT_OK;
				res_q.data     <= '0;
				res_q.position <= '0;
				if (req_data.mode == MODE_ENQ && full) begin
					res_q.status <= STAT_FULL;
				end else if ((req_data.mode == MODE_DEQ || req_data.mode == MODE_SRCH)
					&& empty_q) begin
					res_q.status <= STAT_EMPTY;
				end
			end
			ST_DEQ: begin
				res_q.data <= rd_data;
			end
			ST_SRCH: begin
				slot_q  <= slot_nxt;
				count_q <= count_q + 1'b1;
				if (hit) begin
					res_q.status   <= STAT_OK;
					res_q.position <= pos_ext[POS_W-1:0];
				end else if (slot_q == tail_q) begin
					res_q.status <= STAT_NOTFOUND;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/circular_queue_with_search.sv
`timescale 1ns / 1ps
// enqueue, empty cases and the unused mode go from idle straight to the done state;
// dequeue passes through a read state; search compares k entries (1 to DEPTH) in its walk
// state before done; the controller takes no request until the previous result has moved
// to the output register; the search walk reads one stored entry per cycle through the
// single memory read port
// reset: arst_n clears the queue to empty with head and tail at zero; store is not cleared
module circular_queue_with_search #(
	parameter int DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cqs_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cqs_pkg::rsp_t  rsp_data
);
	import cqs_pkg::*;

	localparam int AW = $clog2(DEPTH);

	// memory port between controller and store
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] rd_data;

	// finished result from the controller
	logic              res_valid;
	logic              res_take;
	rsp_t              res;

	// output register
	logic              rsp_valid_q;
	rsp_t              rsp_data_q;

	cqs_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	cqs_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	// output slot is free when empty or being drained this cycle
	assign res_take = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= res_valid;
		end
	end

	// payload holds while stalled
	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			rsp_data_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule
